### sv/bilinear_integer_upscaler_unit_macros.svh
// Assertion macros used by the upscaler top-level RTL file.
`ifndef BILINEAR_INTEGER_UPSCALER_UNIT_MACROS_SVH
`define BILINEAR_INTEGER_UPSCALER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define BIU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define BIU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### sv/biu_pkg.sv
// ----------------------------------------------------------------------------
// biu_pkg
// Types, constants and register indexes of the bilinear upscaler.
// ----------------------------------------------------------------------------
`default_nettype none
package biu_pkg;
	localparam int MaxWidth  = 1024;
	localparam int MaxScale  = 7;
	localparam int MaxHeight = 4096;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int RowW      = $clog2(MaxHeight);

	localparam logic [1:0] RegScale  = 2'd0;
	localparam logic [1:0] RegWidth  = 2'd1;
	localparam logic [1:0] RegHeight = 2'd2;
	localparam logic [1:0] RegMode   = 2'd3;

	typedef struct packed {
		logic [7:0] ch0;
		logic [7:0] ch1;
		logic [7:0] ch2;
	} pix_t;

	typedef struct packed {
		logic [14:0] out_row;
		logic [12:0] out_col;
		logic [7:0]  res_ch0;
		logic [7:0]  res_ch1;
		logic [7:0]  res_ch2;
		logic        last_of_run;
	} res_t;

	// Request to the shared interpolation unit.
	typedef struct packed {
		logic        start;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [2:0]  t;
		logic [2:0]  k;
	} lerp_req_t;
endpackage
`default_nettype wire

### sv/biu_if.sv
// ----------------------------------------------------------------------------
// biu_if
// Valid/ready channel interfaces of the upscaler.
// ----------------------------------------------------------------------------
`default_nettype none
interface biu_pix_if import biu_pkg::*; ();
	logic valid;
	logic ready;
	pix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface biu_res_if import biu_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface biu_cfg_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### sv/biu_lerp.sv
// ----------------------------------------------------------------------------
// biu_lerp
// Shared interpolation unit: floor(((k-t)a + t*b)/k), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module biu_lerp import biu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire lerp_req_t req,
	output logic           busy,
	output logic           done,
	output logic [7:0]     q
);
	logic [10:0] num_q;
	logic [2:0]  den_q;
	logic [10:0] quo_q;
	logic [3:0]  rem_q;
	logic [3:0]  cnt_q;
	logic [10:0] num_d;
	logic [3:0]  trial;

	// Weighted sum, one small product per operand.
	always_comb begin
		num_d = 11'((req.k - req.t) * req.a) + 11'(req.t * req.b);
		trial = {rem_q[2:0], num_q[10]};
	end

	// Restoring division, eleven steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				cnt_q <= 4'd11;
			end else if (cnt_q != 4'd0) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num_d;
			den_q <= req.k;
			quo_q <= '0;
			rem_q <= '0;
		end else if (cnt_q != 4'd0) begin
			num_q <= {num_q[9:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[9:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[9:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 4'd0);
	assign q    = quo_q[7:0];
endmodule
`default_nettype wire

### sv/bilinear_integer_upscaler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_integer_upscaler_unit
// Integer-factor bilinear upscaler over a raster stream of source pixels.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// cfg      in   index, wdata (scale, width, height, mode)
// pix_in   in   ch0..ch2
// res_out  out  out_row, out_col, res_ch0..res_ch2, last_of_run
// Every interpolated value runs on one shared divider: a start, eleven
// quotient steps and a result. Right-edge and corner results need no
// division; any other result costs three such passes plus an output state,
// and each output row of a block but the bottom one first costs six passes
// for the vertical values. A pixel of the first row or column only fills the
// row store. The row store is a single-port memory. No clearing pass; reset
// restarts the frame. The block holds while res_out is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bilinear_integer_upscaler_unit_macros.svh"
module bilinear_integer_upscaler_unit import biu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	biu_cfg_if.sink   cfg,
	biu_pix_if.sink   pix_in,
	biu_res_if.source res_out
);
	typedef enum logic [6:0] {
		StIdle = 7'b0000001,
		StRead = 7'b0000010,
		StV    = 7'b0000100,
		StH    = 7'b0001000,
		StOut  = 7'b0010000,
		StDone = 7'b0100000,
		StWr   = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [2:0]  k_q;
	logic [10:0] w_q;
	logic [12:0] h_q;
	logic        mode_q;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	pix_t        cur_q, left_q, ul_q, ur_q;
	pix_t        mem [MaxWidth];
	pix_t        rd_s1;
	pix_t        v0_q, v1_q, val_q;
	logic [2:0]  n_q, m_q;
	logic [1:0]  ch_q, ph_q;
	logic        bot_q, edge_q;
	res_t        res_q;
	logic        outv_q;
	logic        start_q;

	logic [2:0]  k_e;
	logic [10:0] w_e;
	logic [12:0] h_e;
	logic        lastcol, lastrow;
	lerp_req_t   req;
	logic        lbusy, ldone;
	logic [7:0]  lq;
	logic [7:0]  ea, eb, rv;
	logic [2:0]  et;
	logic [2:0]  nmax, mmax;
	logic [14:0] r_out;
	logic [12:0] c_out;
	logic        final_res;

	// Effective configuration.
	always_comb begin
		k_e = (k_q == 3'd0) ? 3'd1 : k_q;
		w_e = (w_q < 11'd2) ? 11'd2 : ((w_q > 11'(MaxWidth)) ? 11'(MaxWidth) : w_q);
		h_e = (h_q < 13'd2) ? 13'd2 : ((h_q > 13'(MaxHeight)) ? 13'(MaxHeight) : h_q);
		lastcol = ({1'b0, col_q} == w_e - 11'd1);
		lastrow = ({1'b0, row_q} == h_e - 13'd1);
	end

	// Channel select helpers.
	function automatic logic [7:0] pick(input pix_t p, input logic [1:0] c);
		logic [7:0] r;
		case (c)
			2'd0: r = p.ch0;
			2'd1: r = p.ch1;
			default: r = p.ch2;
		endcase
		return r;
	endfunction

	function automatic pix_t put(input pix_t p, input logic [1:0] c, input logic [7:0] v);
		pix_t r;
		r = p;
		case (c)
			2'd0: r.ch0 = v;
			2'd1: r.ch1 = v;
			default: r.ch2 = v;
		endcase
		return r;
	endfunction

	// Operand select: phase 0 left column v0, phase 1 right column v1, phase 2 horizontal.
	always_comb begin
		case (ph_q)
			2'd0: begin ea = pick(ul_q, ch_q); eb = pick(left_q, ch_q); et = n_q; end
			2'd1: begin ea = pick(ur_q, ch_q); eb = pick(cur_q, ch_q); et = n_q; end
			default: begin ea = pick(v0_q, ch_q); eb = pick(v1_q, ch_q); et = m_q; end
		endcase
		req.start = start_q;
		req.a = ea;
		req.b = eb;
		req.t = et;
		req.k = k_e;
	end

	// Loop bounds: n runs k rows plus the bottom row; m runs k plus right edge.
	assign nmax = k_e - 3'd1;
	assign mmax = lastcol ? k_e : k_e - 3'd1;
	assign r_out = 15'((row_q - 12'd1) * k_e) + (bot_q ? 15'(k_e) : 15'(n_q));
	assign c_out = 13'((col_q - 10'd1) * k_e) + 13'(m_q);
	assign final_res = (m_q == mmax) && (bot_q || (!lastrow && n_q == nmax));
	assign rv = (edge_q) ? pick(v1_q, ch_q) : lq;

	biu_lerp u_lerp (
		.clk(clk), .arst_n(arst_n), .req(req),
		.busy(lbusy), .done(ldone), .q(lq)
	);

	// A register write takes precedence over a pixel in the same cycle.
	assign cfg.ready    = (state_q == StIdle);
	assign pix_in.ready = (state_q == StIdle) && !cfg.valid;
	assign res_out.valid = outv_q;
	assign res_out.data  = res_q;

	// Row store port: read at acceptance, written back at the end.
	always_ff @(posedge clk) begin
		if (state_q == StWr) begin
			mem[col_q] <= cur_q;
		end
		rd_s1 <= mem[col_q];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			k_q <= 3'd2; w_q <= 11'd1024; h_q <= 13'd1024; mode_q <= 1'b1;
			col_q <= '0; row_q <= '0;
			left_q <= '0; ul_q <= '0;
			outv_q <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (outv_q && res_out.ready) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (cfg.valid) begin
						case (cfg.index)
							RegScale:  k_q <= cfg.wdata[2:0];
							RegWidth:  w_q <= cfg.wdata[10:0];
							RegHeight: h_q <= cfg.wdata[12:0];
							default:   mode_q <= cfg.wdata[0];
						endcase
						col_q <= '0; row_q <= '0; left_q <= '0; ul_q <= '0;
					end else if (pix_in.valid) begin
						cur_q.ch0 <= pix_in.data.ch0;
						cur_q.ch1 <= mode_q ? pix_in.data.ch1 : 8'd0;
						cur_q.ch2 <= mode_q ? pix_in.data.ch2 : 8'd0;
						state_q <= StRead;
					end
				end
				StRead: begin
					ur_q <= rd_s1;
					n_q <= '0; m_q <= '0; ch_q <= '0; ph_q <= '0; bot_q <= 1'b0;
					edge_q <= 1'b0;
					if (row_q != '0 && col_q != '0) begin
						start_q <= 1'b1;
						state_q <= StV;
					end else begin
						state_q <= StWr;
					end
				end
				StV: begin
					if (ldone) begin
						if (ph_q == 2'd0) v0_q <= put(v0_q, ch_q, lq);
						else v1_q <= put(v1_q, ch_q, lq);
						if (ch_q == 2'd2) begin
							ch_q <= '0;
							if (ph_q == 2'd0) begin
								ph_q <= 2'd1;
								start_q <= 1'b1;
							end else begin
								ph_q <= 2'd2;
								edge_q <= (m_q == k_e);
								if (m_q != k_e) start_q <= 1'b1;
								state_q <= StH;
							end
						end else begin
							ch_q <= ch_q + 2'd1;
							start_q <= 1'b1;
						end
					end
				end
				StH: begin
					if (ldone || (edge_q && !lbusy && !start_q)) begin
						val_q <= put(val_q, ch_q, rv);
						if (ch_q == 2'd2) begin
							ch_q <= '0;
							state_q <= StOut;
						end else begin
							ch_q <= ch_q + 2'd1;
							if (!edge_q) start_q <= 1'b1;
						end
					end
				end
				StOut: begin
					if (!outv_q || res_out.ready) begin
						outv_q <= 1'b1;
						res_q.out_row <= r_out;
						res_q.out_col <= c_out;
						res_q.res_ch0 <= val_q.ch0;
						res_q.res_ch1 <= val_q.ch1;
						res_q.res_ch2 <= val_q.ch2;
						res_q.last_of_run <= final_res;
						if (m_q != mmax) begin
							m_q <= m_q + 3'd1;
							edge_q <= (m_q + 3'd1 == k_e);
							state_q <= StH;
							if (m_q + 3'd1 != k_e) start_q <= 1'b1;
						end else if (final_res) begin
							state_q <= StWr;
						end else begin
							m_q <= '0;
							edge_q <= 1'b0;
							if (n_q == nmax) begin
								// Bottom row: interpolate left pixel to current.
								bot_q <= 1'b1;
								v0_q <= left_q;
								v1_q <= cur_q;
								start_q <= 1'b1;
								state_q <= StH;
							end else begin
								n_q <= n_q + 3'd1;
								ph_q <= 2'd0;
								start_q <= 1'b1;
								state_q <= StV;
							end
						end
					end
				end
				StWr: begin
					ul_q <= ur_q;
					left_q <= cur_q;
					if (lastcol) begin
						col_q <= '0;
						row_q <= lastrow ? '0 : row_q + 12'd1;
					end else begin
						col_q <= col_q + 10'd1;
					end
					state_q <= StDone;
				end
				StDone: begin
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`BIU_ASSERT_IMP(a_ready_idle, clk, arst_n, pix_in.ready, state_q == StIdle, "ready outside idle")
	`BIU_ASSERT_NXT(a_hold, clk, arst_n, res_out.valid && !res_out.ready, res_out.valid && $stable(res_out.data), "result dropped")
	`BIU_ASSERT_IMP(a_col, clk, arst_n, state_q == StIdle, {1'b0, col_q} < w_e, "column out of range")
endmodule
`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear integer upscaler. Random source frames
// stream in under bursty input and a stalling receiver. A local model of the
// upscaler predicts every output pixel, and each result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb import biu_pkg::*; ();

	localparam int CycleLimit = 4000000;
	localparam int SettleCycles = 200;
	localparam int LongHold = 3000;

	logic clk;
	logic arst_n;

	biu_cfg_if cfg_if ();
	biu_pix_if pix_if ();
	biu_res_if res_if ();

	bilinear_integer_upscaler_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if),
		.pix_in  (pix_if),
		.res_out (res_if)
	);

	// Local copy of the upscaler state and registers.
	logic [2:0]  scale_reg;
	logic [10:0] width_reg;
	logic [12:0] height_reg;
	logic        mode_reg;
	logic [7:0]  row_store [MaxWidth][3];
	int          left_px [3];
	int          upleft_px [3];
	int          src_col;
	int          src_row;

	pix_t pix_pending [$];
	res_t upscaled_due [$];

	int cycles;
	int pixels_in;
	int results_seen;
	int mismatches;
	int random_items;
	int phases;
	bit pix_took;
	int burst_left;
	int gap_left;
	bit hold_go;
	bit hold_seen;
	int hold_left;
	int rx_mode;
	int rx_count;
	int stall_left;

	always #5 clk = ~clk;

	// One interpolation step with exact integer division.
	function automatic int blend(int a, int b, int t, int kk);
		return ((kk - t) * a + t * b) / kk;
	endfunction

	task automatic push_res(int r, int c, int v0, int v1, int v2);
		res_t e;
		e.out_row = r[14:0];
		e.out_col = c[12:0];
		e.res_ch0 = v0[7:0];
		e.res_ch1 = v1[7:0];
		e.res_ch2 = v2[7:0];
		e.last_of_run = 1'b0;
		upscaled_due = {upscaled_due, e};
	endtask

	// Apply one register write to the local state; any write restarts the frame.
	task automatic apply_reg(logic [1:0] idx, logic [12:0] val);
		case (idx)
			RegScale: begin
				scale_reg = val[2:0];
			end
			RegWidth: begin
				width_reg = val[10:0];
			end
			RegHeight: begin
				height_reg = val[12:0];
			end
			default: begin
				mode_reg = val[0];
			end
		endcase
		src_col = 0;
		src_row = 0;
		for (int c = 0; c < 3; c++) begin
			left_px[c] = 0;
			upleft_px[c] = 0;
		end
	endtask

	// Work out the output block that one accepted source pixel produces.
	task automatic upscale_pixel(pix_t p);
		int kk, ww, hh, i, j, cnt0;
		int cur [3];
		int ul [3];
		int ur [3];
		int lf [3];
		int v0 [3];
		int v1 [3];
		int v [3];
		res_t e;
		kk = (scale_reg == 0) ? 1 : int'(scale_reg);
		ww = int'(width_reg);
		if (ww < 2) ww = 2;
		if (ww > MaxWidth) ww = MaxWidth;
		hh = int'(height_reg);
		if (hh < 2) hh = 2;
		if (hh > MaxHeight) hh = MaxHeight;
		if (src_col >= ww) src_col = 0;
		if (src_row >= hh) src_row = 0;
		i = src_row;
		j = src_col;
		cur[0] = int'(p.ch0);
		cur[1] = mode_reg ? int'(p.ch1) : 0;
		cur[2] = mode_reg ? int'(p.ch2) : 0;
		for (int c = 0; c < 3; c++) begin
			ur[c] = int'(row_store[j][c]);
			ul[c] = upleft_px[c];
			lf[c] = left_px[c];
		end
		cnt0 = upscaled_due.size();
		if (i >= 1 && j >= 1) begin
			for (int n = 0; n < kk; n++) begin
				for (int c = 0; c < 3; c++) begin
					v0[c] = blend(ul[c], lf[c], n, kk);
					v1[c] = blend(ur[c], cur[c], n, kk);
				end
				for (int m = 0; m < kk; m++) begin
					for (int c = 0; c < 3; c++)
						v[c] = blend(v0[c], v1[c], m, kk);
					push_res((i - 1) * kk + n, (j - 1) * kk + m, v[0], v[1], v[2]);
				end
				if (j == ww - 1)
					push_res((i - 1) * kk + n, j * kk, v1[0], v1[1], v1[2]);
			end
			// Bottom output row and the bottom-right corner.
			if (i == hh - 1) begin
				for (int m = 0; m < kk; m++) begin
					for (int c = 0; c < 3; c++)
						v[c] = blend(lf[c], cur[c], m, kk);
					push_res(i * kk, (j - 1) * kk + m, v[0], v[1], v[2]);
				end
				if (j == ww - 1)
					push_res(i * kk, j * kk, cur[0], cur[1], cur[2]);
			end
			if (upscaled_due.size() > cnt0) begin
				e = upscaled_due[$];
				e.last_of_run = 1'b1;
				upscaled_due[upscaled_due.size() - 1] = e;
			end
		end
		for (int c = 0; c < 3; c++) begin
			upleft_px[c] = ur[c];
			row_store[j][c] = cur[c][7:0];
			left_px[c] = cur[c];
		end
		src_col = j + 1;
		if (src_col >= ww) begin
			src_col = 0;
			src_row = i + 1;
			if (src_row >= hh) src_row = 0;
		end
	endtask

	// Input acceptance, result checking and the run limit.
	always @(posedge clk) begin
		res_t e;
		res_t a;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb: timeout after %0d cycles, %0d results pending",
				cycles, upscaled_due.size());
			$display("tb: done, errors");
			$finish;
		end
		pix_took <= arst_n && pix_if.valid && pix_if.ready;
		if (arst_n && pix_if.valid && pix_if.ready) begin
			upscale_pixel(pix_if.data);
			pixels_in++;
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			a = res_if.data;
			results_seen++;
			if (upscaled_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected result row %0d col %0d", a.out_row, a.out_col);
			end else begin
				e = upscaled_due.pop_front();
				if (a.out_row !== e.out_row || a.out_col !== e.out_col ||
						a.res_ch0 !== e.res_ch0 || a.res_ch1 !== e.res_ch1 ||
						a.res_ch2 !== e.res_ch2 || a.last_of_run !== e.last_of_run) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"tb: mismatch exp r%0d c%0d %0d/%0d/%0d last %0d,",
							" got r%0d c%0d %0d/%0d/%0d last %0d"},
							e.out_row, e.out_col, e.res_ch0, e.res_ch1, e.res_ch2,
							e.last_of_run, a.out_row, a.out_col, a.res_ch0, a.res_ch1,
							a.res_ch2, a.last_of_run);
				end
			end
		end
	end

	// Pixel driver: bursts of random length with random gaps between them.
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
		end else if (pix_if.valid && !pix_took) begin
			// Item still offered; hold it.
		end else if (gap_left > 0) begin
			gap_left--;
			pix_if.valid <= 1'b0;
		end else if (pix_pending.size() > 0) begin
			pix_if.valid <= 1'b1;
			pix_if.data <= pix_pending.pop_front();
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 16);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			pix_if.valid <= 1'b0;
		end
	end

	// Result receiver: a changing stall pattern, plus one long hold on request.
	always @(negedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = LongHold;
		end
		rx_count++;
		if (rx_count % 300 == 0) rx_mode = $urandom_range(0, 3);
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: begin
					res_if.ready <= 1'b1;
				end
				1: begin
					res_if.ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					res_if.ready <= ($urandom_range(0, 7) != 0);
				end
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						res_if.ready <= 1'b0;
					end else begin
						res_if.ready <= 1'b1;
						if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
					end
				end
			endcase
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.wdata <= val;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_regs(int k, int w, int h, int mode);
		write_reg(RegScale, 13'(k));
		write_reg(RegWidth, 13'(w));
		write_reg(RegHeight, 13'(h));
		write_reg(RegMode, 13'(mode));
		phases++;
	endtask

	// Wait until every queued item is taken and every expected result is back.
	task automatic wait_drained();
		while (pix_pending.size() > 0 || pix_if.valid || upscaled_due.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic queue_pixels(int n);
		pix_t p;
		for (int q = 0; q < n; q++) begin
			p.ch0 = 8'($urandom_range(0, 255));
			p.ch1 = 8'($urandom_range(0, 255));
			p.ch2 = 8'($urandom_range(0, 255));
			pix_pending = {pix_pending, p};
		end
	endtask

	initial begin
		pix_t p;
		int k, w, h, frames;
		clk = 1'b0;
		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.data = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = RegScale;
		cfg_if.wdata = '0;
		burst_left = 1;
		rx_mode = 0;
		scale_reg = 3'd2;
		width_reg = 11'd1024;
		height_reg = 13'd1024;
		mode_reg = 1'b1;
		apply_reg(RegMode, 13'd1);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: full 3x3 frame of extreme values, with edges, corner and wrap.
		set_regs(2, 3, 3, 1);
		for (int q = 0; q < 11; q++) begin
			p.ch0 = (q % 2) ? 8'hFF : 8'h00;
			p.ch1 = (q % 3) ? 8'h00 : 8'hFF;
			p.ch2 = (q % 4 < 2) ? 8'hFF : 8'h00;
			pix_pending = {pix_pending, p};
		end
		wait_drained();
		// Gray mode at the largest factor; the other channels must be ignored.
		set_regs(7, 2, 2, 0);
		for (int q = 0; q < 4; q++) begin
			p.ch0 = (q == 3) ? 8'hFF : 8'h00;
			p.ch1 = 8'hFF;
			p.ch2 = 8'hFF;
			pix_pending = {pix_pending, p};
		end
		wait_drained();
		// Out-of-range factor and sizes saturate.
		set_regs(0, 1, 0, 1);
		queue_pixels(6);
		wait_drained();

		// Oversized width and height saturate; the start of the first row only fills the store.
		set_regs(1, 2047, 8191, 0);
		queue_pixels(8);
		wait_drained();

		// Random frames, mostly complete, some cut short by a register write.
		while (random_items < 150 || phases < 10) begin
			k = $urandom_range(0, 7);
			w = $urandom_range(2, 6);
			h = $urandom_range(2, 5);
			set_regs(k, w, h, $urandom_range(0, 1));
			if (phases == 8) begin
				// Long receiver hold at a high factor fills the block.
				set_regs(6, 4, 3, 1);
				w = 4;
				h = 3;
				hold_go = ~hold_go;
			end
			frames = $urandom_range(1, 2);
			if ($urandom_range(0, 4) == 0) begin
				queue_pixels($urandom_range(1, w * h - 1));
				random_items += pix_pending.size();
			end else begin
				queue_pixels(w * h * frames);
				random_items += w * h * frames;
			end
			if (phases == 10) begin
				// Sender pauses until every result is back, then resumes mid-stream.
				wait_drained();
				queue_pixels(w * h);
				random_items += w * h;
			end
			wait_drained();
		end

		$display("tb: %0d source pixels over %0d register settings, %0d output pixels checked",
			pixels_in, phases, results_seen);
		$display("tb: %0d mismatches", mismatches);
		if (mismatches == 0 && upscaled_due.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
